// ===== src/pchc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the path cost hash cache: field widths, codes, hash constants
// and the command and status structs between controller and datapath.
// No dependencies; every other file of the block imports it.
package pchc_pkg;

  // Fixed widths of the channel fields.
  localparam int OP_W       = 2;
  localparam int FCOORD_W   = 10;
  localparam int COST_W     = 31;
  localparam int OUTCOME_W  = 3;
  localparam int SLOT_W     = 13;

  // Defaults of the top-level parameters.
  localparam int CAPACITY_DEF   = 8192;
  localparam int COORD_BITS_DEF = 10;

  // Hash word and the remainder unit that reduces it.
  localparam int HASH_W       = 32;
  localparam int HASH_TERMS   = 4;
  localparam int MOD_STEPS    = 4;
  localparam int MOD_CYCLES   = HASH_W / MOD_STEPS;
  localparam int MOD_CNT_W    = $clog2(MOD_CYCLES + 1);

  localparam logic [HASH_W-1:0] HASH_K [HASH_TERMS] = '{
    32'd73856093, 32'd19349663, 32'd83492791, 32'd50331653
  };

  // Replacement LFSR.
  localparam int              LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  // Operation codes on the input channel.
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Outcome codes on the result channel.
  typedef enum logic [OUTCOME_W-1:0] {
    OUT_MISS     = 3'd0,
    OUT_HIT      = 3'd1,
    OUT_FILLED   = 3'd2,
    OUT_UPDATED  = 3'd3,
    OUT_REPLACED = 3'd4,
    OUT_CLEARED  = 3'd5
  } outcome_t;

  // Where a table write goes and what it carries.
  typedef enum logic [1:0] {
    WR_INVALID,
    WR_AT_POS,
    WR_AT_REPL
  } wr_mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     hash_step;
    logic     mod_load;
    logic     mod_from_lfsr;
    logic     probe_start;
    logic     probe_step;
    logic     lfsr_step;
    logic     mem_we;
    wr_mode_t wr_mode;
    logic     clr_step;
    logic     res_load;
    outcome_t res_code;
    logic     out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hash_last;
    logic mod_done;
    logic slot_empty;
    logic key_match;
    logic probe_last;
    logic clr_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/pchc_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the path cost hash cache: valid, ready and one request item.
// Depends on pchc_pkg for the field widths.
interface pchc_in_if;
  import pchc_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [FCOORD_W-1:0] src_row;
  logic [FCOORD_W-1:0] src_col;
  logic [FCOORD_W-1:0] dst_row;
  logic [FCOORD_W-1:0] dst_col;
  logic [COST_W-1:0]   cost_in;

  modport source (
    output valid, op, src_row, src_col, dst_row, dst_col, cost_in,
    input  ready
  );

  modport sink (
    input  valid, op, src_row, src_col, dst_row, dst_col, cost_in,
    output ready
  );

endinterface

// ===== src/pchc_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the path cost hash cache: valid, ready and one result item.
// Depends on pchc_pkg for the field widths.
interface pchc_out_if;
  import pchc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [COST_W-1:0]    cost_out;
  logic [SLOT_W-1:0]    slot;

  modport source (
    output valid, outcome, cost_out, slot,
    input  ready
  );

  modport sink (
    input  valid, outcome, cost_out, slot,
    output ready
  );

endinterface

// ===== src/pchc_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the path cost hash cache: sequences hashing, slot reduction,
// probing, replacement, clearing and result delivery. Depends on pchc_pkg.
module pchc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [pchc_pkg::OP_W-1:0] in_op,
  output logic                   in_ready,
  input  pchc_pkg::dp_status_t   st,
  output pchc_pkg::ctrl_cmd_t    cmd
);
  import pchc_pkg::*;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_HASH,
    S_MLOAD,
    S_MWAIT,
    S_PROBE,
    S_RLOAD,
    S_RWAIT,
    S_CLEAR,
    S_DELIVER
  } state_t;

  state_t          state_r, state_nxt;
  logic            in_ready_r, in_ready_nxt;
  logic [OP_W-1:0] op_r, op_nxt;
  logic            is_insert;

  assign in_ready  = in_ready_r;
  assign is_insert = (op_r == OP_INSERT);

  // Next state and the commands of the current cycle.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.wr_mode  = WR_INVALID;
    cmd.res_code = OUT_MISS;

    case (state_r)
      S_INIT: begin
        // Sweep the table once after reset, marking every slot invalid.
        cmd.mem_we   = 1'b1;
        cmd.wr_mode  = WR_INVALID;
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.capture = 1'b1;
          op_nxt      = in_op;
          if (in_op inside {OP_LOOKUP, OP_INSERT}) begin
            state_nxt = S_HASH;
          end else if (in_op == OP_CLEAR) begin
            state_nxt = S_CLEAR;
          end else begin
            // An unused operation yields a plain miss.
            cmd.res_load = 1'b1;
            cmd.res_code = OUT_MISS;
            state_nxt    = S_DELIVER;
          end
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (st.hash_last) begin
          state_nxt = S_MLOAD;
        end
      end
      S_MLOAD: begin
        cmd.mod_load = 1'b1;
        state_nxt    = S_MWAIT;
      end
      S_MWAIT: begin
        // The home slot is ready; its read is issued now.
        if (st.mod_done) begin
          cmd.probe_start = 1'b1;
          state_nxt       = S_PROBE;
        end
      end
      S_PROBE: begin
        if (st.slot_empty) begin
          cmd.res_load = 1'b1;
          if (is_insert) begin
            cmd.mem_we   = 1'b1;
            cmd.wr_mode  = WR_AT_POS;
            cmd.res_code = OUT_FILLED;
          end else begin
            cmd.res_code = OUT_MISS;
          end
          state_nxt = S_DELIVER;
        end else if (st.key_match) begin
          cmd.res_load = 1'b1;
          if (is_insert) begin
            cmd.mem_we   = 1'b1;
            cmd.wr_mode  = WR_AT_POS;
            cmd.res_code = OUT_UPDATED;
          end else begin
            cmd.res_code = OUT_HIT;
          end
          state_nxt = S_DELIVER;
        end else if (st.probe_last) begin
          // Every slot was probed without a match or a free slot.
          if (is_insert) begin
            cmd.lfsr_step = 1'b1;
            state_nxt     = S_RLOAD;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_code = OUT_MISS;
            state_nxt    = S_DELIVER;
          end
        end else begin
          cmd.probe_step = 1'b1;
        end
      end
      S_RLOAD: begin
        cmd.mod_load      = 1'b1;
        cmd.mod_from_lfsr = 1'b1;
        state_nxt         = S_RWAIT;
      end
      S_RWAIT: begin
        if (st.mod_done) begin
          cmd.mem_we   = 1'b1;
          cmd.wr_mode  = WR_AT_REPL;
          cmd.res_load = 1'b1;
          cmd.res_code = OUT_REPLACED;
          state_nxt    = S_DELIVER;
        end
      end
      S_CLEAR: begin
        cmd.mem_we   = 1'b1;
        cmd.wr_mode  = WR_INVALID;
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          cmd.res_load = 1'b1;
          cmd.res_code = OUT_CLEARED;
          state_nxt    = S_DELIVER;
        end
      end
      S_DELIVER: begin
        // Wait until the output register is free, then hand the result over.
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    in_ready_nxt = (state_nxt == S_IDLE);
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      in_ready_r <= 1'b0;
      op_r       <= OP_LOOKUP;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
      op_r       <= op_nxt;
    end
  end

endmodule

// ===== src/pchc_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the path cost hash cache: hash accumulator, slot remainder unit,
// slot table memory, probe and sweep counters, LFSR and result registers.
// Depends on pchc_pkg; driven by pchc_ctrl through ctrl_cmd_t.
module pchc_datapath #(
  parameter int CAPACITY   = pchc_pkg::CAPACITY_DEF,
  parameter int COORD_BITS = pchc_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pchc_pkg::ctrl_cmd_t            cmd,
  output pchc_pkg::dp_status_t           st,
  input  logic [pchc_pkg::FCOORD_W-1:0]  in_src_row,
  input  logic [pchc_pkg::FCOORD_W-1:0]  in_src_col,
  input  logic [pchc_pkg::FCOORD_W-1:0]  in_dst_row,
  input  logic [pchc_pkg::FCOORD_W-1:0]  in_dst_col,
  input  logic [pchc_pkg::COST_W-1:0]    in_cost_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pchc_pkg::OUTCOME_W-1:0] out_outcome,
  output logic [pchc_pkg::COST_W-1:0]    out_cost_out,
  output logic [pchc_pkg::SLOT_W-1:0]    out_slot
);
  import pchc_pkg::*;

  localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int KW      = 4 * COORD_BITS;
  localparam int MW      = 1 + KW + COST_W;
  localparam bit IS_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
  localparam logic [AW:0]   CAP_EXT   = (AW + 1)'(CAPACITY);

  // Captured request.
  logic [COORD_BITS-1:0] crd_r [HASH_TERMS];
  logic [COST_W-1:0]     cost_r;
  logic [KW-1:0]         key;
  logic [15:0]           f_src_row, f_src_col, f_dst_row, f_dst_col;

  // Hash accumulator.
  logic [HASH_W-1:0]     hash_acc_r;
  logic [1:0]            hash_cnt_r;
  logic [HASH_W-1:0]     hash_prod;

  // Remainder unit.
  logic [HASH_W-1:0]     mod_src_r;
  logic [AW-1:0]         rem_r;
  logic [MOD_CNT_W-1:0]  mod_cnt_r;
  logic [HASH_W-1:0]     mod_src_nxt;
  logic [AW-1:0]         rem_nxt;
  logic [AW-1:0]         mod_result;

  // Probe position, counters and LFSR.
  logic [AW-1:0]         pos_r;
  logic [AW-1:0]         next_pos;
  logic [AW-1:0]         probe_cnt_r;
  logic [AW-1:0]         clr_cnt_r;
  logic [LFSR_W-1:0]     lfsr_r;
  logic                  lfsr_fb;

  // Slot table.
  logic [MW-1:0]         mem_r [CAPACITY];
  logic [MW-1:0]         rd_data_r;
  logic [MW-1:0]         wr_data;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic                  rd_valid;
  logic [KW-1:0]         rd_key;
  logic [COST_W-1:0]     rd_cost;

  // Result staging and output register.
  logic [OUTCOME_W-1:0]  res_outcome_r;
  logic [COST_W-1:0]     res_cost_r;
  logic [SLOT_W-1:0]     res_slot_r;
  logic [15:0]           res_slot_ext;
  logic [COST_W-1:0]     res_cost;
  logic                  out_valid_r;
  logic [OUTCOME_W-1:0]  out_outcome_r;
  logic [COST_W-1:0]     out_cost_r;
  logic [SLOT_W-1:0]     out_slot_r;

  // Coordinates keep their low COORD_BITS bits.
  assign f_src_row = 16'(in_src_row);
  assign f_src_col = 16'(in_src_col);
  assign f_dst_row = 16'(in_dst_row);
  assign f_dst_col = 16'(in_dst_col);
  assign key = {crd_r[0], crd_r[1], crd_r[2], crd_r[3]};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      crd_r[0] <= f_src_row[COORD_BITS-1:0];
      crd_r[1] <= f_src_col[COORD_BITS-1:0];
      crd_r[2] <= f_dst_row[COORD_BITS-1:0];
      crd_r[3] <= f_dst_col[COORD_BITS-1:0];
      cost_r   <= in_cost_in;
    end
  end

  // Hash: one coordinate times its constant per cycle, summed modulo 2^32.
  assign hash_prod = HASH_W'(crd_r[hash_cnt_r]) * HASH_K[hash_cnt_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_cnt_r <= 2'd0;
    end else if (cmd.capture) begin
      hash_cnt_r <= 2'd0;
    end else if (cmd.hash_step) begin
      hash_cnt_r <= hash_cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hash_acc_r <= '0;
    end else if (cmd.hash_step) begin
      hash_acc_r <= hash_acc_r + hash_prod;
    end
  end

  // Remainder by CAPACITY, MOD_STEPS restoring steps per cycle.
  always_comb begin
    logic [AW:0]       trial;
    logic [HASH_W-1:0] src_v;
    logic [AW-1:0]     rem_v;
    src_v = mod_src_r;
    rem_v = rem_r;
    for (int k = 0; k < MOD_STEPS; k++) begin
      trial = {rem_v, src_v[HASH_W-1]};
      src_v = {src_v[HASH_W-2:0], 1'b0};
      if (trial >= CAP_EXT) begin
        trial = trial - CAP_EXT;
      end
      rem_v = trial[AW-1:0];
    end
    mod_src_nxt = src_v;
    rem_nxt     = rem_v;
  end

  assign mod_result = IS_POW2 ? mod_src_r[AW-1:0] : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_cnt_r <= '0;
    end else if (cmd.mod_load) begin
      mod_cnt_r <= IS_POW2 ? '0 : MOD_CNT_W'(MOD_CYCLES);
    end else if (mod_cnt_r != '0) begin
      mod_cnt_r <= mod_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_load) begin
      mod_src_r <= cmd.mod_from_lfsr ? HASH_W'(lfsr_r) : hash_acc_r;
      rem_r     <= '0;
    end else if (!IS_POW2 && mod_cnt_r != '0) begin
      mod_src_r <= mod_src_nxt;
      rem_r     <= rem_nxt;
    end
  end

  // Linear probe position and probe count.
  assign next_pos = (pos_r == LAST_SLOT) ? '0 : pos_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.probe_start) begin
      pos_r       <= mod_result;
      probe_cnt_r <= '0;
    end else if (cmd.probe_step) begin
      pos_r       <= next_pos;
      probe_cnt_r <= probe_cnt_r + 1'b1;
    end
  end

  // Sweep counter for the invalidation passes; it wraps back to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= (clr_cnt_r == LAST_SLOT) ? '0 : clr_cnt_r + 1'b1;
    end
  end

  // Replacement LFSR, x^16 + x^14 + x^13 + x^11 + 1, shifting right.
  assign lfsr_fb = lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= LFSR_SEED;
    end else if (cmd.lfsr_step) begin
      lfsr_r <= {lfsr_fb, lfsr_r[LFSR_W-1:1]};
    end
  end

  // Table write port: address and data by write mode.
  always_comb begin
    case (cmd.wr_mode)
      WR_INVALID: begin
        wr_addr = clr_cnt_r;
        wr_data = '0;
      end
      WR_AT_POS: begin
        wr_addr = pos_r;
        wr_data = {1'b1, key, cost_r};
      end
      WR_AT_REPL: begin
        wr_addr = mod_result;
        wr_data = {1'b1, key, cost_r};
      end
      default: begin
        wr_addr = pos_r;
        wr_data = '0;
      end
    endcase
  end

  // The read looks one slot ahead of the probe position, or at the home slot when a probe starts.
  assign rd_addr = cmd.probe_start ? mod_result : next_pos;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_valid = rd_data_r[MW-1];
  assign rd_key   = rd_data_r[MW-2 -: KW];
  assign rd_cost  = rd_data_r[COST_W-1:0];

  // Result fields by outcome.
  always_comb begin
    if (cmd.res_code inside {OUT_HIT, OUT_FILLED, OUT_UPDATED}) begin
      res_slot_ext = 16'(pos_r);
    end else if (cmd.res_code == OUT_REPLACED) begin
      res_slot_ext = 16'(mod_result);
    end else begin
      res_slot_ext = '0;
    end
    res_cost = (cmd.res_code == OUT_HIT) ? rd_cost : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_outcome_r <= cmd.res_code;
      res_cost_r    <= res_cost;
      res_slot_r    <= res_slot_ext[SLOT_W-1:0];
    end
  end

  // Output register, freed when the receiver takes the item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_outcome_r <= res_outcome_r;
      out_cost_r    <= res_cost_r;
      out_slot_r    <= res_slot_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_outcome  = out_outcome_r;
  assign out_cost_out = out_cost_r;
  assign out_slot     = out_slot_r;

  // Status to the controller.
  assign st.hash_last  = (hash_cnt_r == 2'(HASH_TERMS - 1));
  assign st.mod_done   = (mod_cnt_r == '0);
  assign st.slot_empty = !rd_valid;
  assign st.key_match  = rd_valid && (rd_key == key);
  assign st.probe_last = (probe_cnt_r == LAST_SLOT);
  assign st.clr_last   = (clr_cnt_r == LAST_SLOT);
  assign st.out_free   = !out_valid_r || out_ready;

endmodule

// ===== src/path_cost_hash_cache_top.sv =====
`timescale 1ns / 1ps
// Path cost hash cache: an open-addressed table of path costs keyed by source
// and destination coordinates, with linear probing and random replacement.
//
// Usage: a request item (op, coordinates, cost) enters on in_chan and
// exactly one result item (outcome, cost, slot) leaves on out_chan, both with
// valid/ready handshakes. One item is worked on at a time. A lookup or insert
// runs through these steps from acceptance to the next acceptance: hashing of
// the four coordinates through one shared multiplier, a slot reduction, one
// probed slot at a time through the table's read port, loading of the output
// register, and idle with in_chan ready high. An insert into a full table
// adds a second slot reduction for the replacement slot. A clear walks the
// whole table, one slot per cycle. After reset the block sweeps the table
// with in_chan ready low, then accepts items. The output register holds a
// result until it is taken; meanwhile the next item may be accepted and
// worked on, and only its delivery waits while the receiver stalls.
// Depends on pchc_pkg, pchc_in_if, pchc_out_if, pchc_ctrl, pchc_datapath.
module path_cost_hash_cache_top #(
  parameter int CAPACITY   = pchc_pkg::CAPACITY_DEF,
  parameter int COORD_BITS = pchc_pkg::COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pchc_in_if.sink    in_chan,
  pchc_out_if.source out_chan
);
  import pchc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;
  logic       in_ready;

  assign in_chan.ready = in_ready;

  // Sequencer.
  pchc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_op    (in_chan.op),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Hash, table and result path.
  pchc_datapath #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .in_src_row   (in_chan.src_row),
    .in_src_col   (in_chan.src_col),
    .in_dst_row   (in_chan.dst_row),
    .in_dst_col   (in_chan.dst_col),
    .in_cost_in   (in_chan.cost_in),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_outcome  (out_chan.outcome),
    .out_cost_out (out_chan.cost_out),
    .out_slot     (out_chan.slot)
  );

endmodule
